// File: src/teq_pkg.sv
package teq_pkg;

    localparam int SLOTS = 64;
    localparam int CW    = $clog2(SLOTS + 1);

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] EV_REGISTERED = 3'd0;
    localparam logic [2:0] EV_FULL       = 3'd1;
    localparam logic [2:0] EV_CANCELLED  = 3'd2;
    localparam logic [2:0] EV_NOT_FOUND  = 3'd3;
    localparam logic [2:0] EV_EXPIRED    = 3'd4;
    localparam logic [2:0] EV_NOTHING    = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] wake_time;
        logic [15:0] owner_process;
        logic [31:0] user_tag;
        logic [31:0] cancel_handle;
        logic [31:0] now_tick;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  event_kind;
        logic [31:0] handle;
        logic [15:0] fired_owner;
        logic [31:0] fired_tag;
        logic        final_flag;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REG,
        ST_SCAN,
        ST_POP
    } back_state_t;

endpackage

// File: src/teq_front.sv
module teq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  teq_pkg::cmd_t   in_cmd,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output teq_pkg::cmd_t   cmd_head
);

    teq_pkg::cmd_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    // drop undefined opcodes at the door
    assign push      = in_valid && in_ready && (in_cmd.opcode != teq_pkg::OP_RESERVED);
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_head  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: src/teq_back.sv
module teq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  teq_pkg::cmd_t     cmd_head,
    input  logic              out_ready,
    output teq_pkg::result_t  result
);

    localparam int SLOTS = teq_pkg::SLOTS;
    localparam int CW    = teq_pkg::CW;

    teq_pkg::back_state_t state_reg, state_next;
    teq_pkg::cmd_t        cmd_reg;

    logic [31:0] wake_reg  [SLOTS];
    logic [31:0] ident_reg [SLOTS];
    logic [15:0] owner_reg [SLOTS];
    logic [31:0] tag_reg   [SLOTS];
    logic [SLOTS-1:0] alive_reg;
    logic [31:0] wake_next  [SLOTS];
    logic [31:0] ident_next [SLOTS];
    logic [15:0] owner_next [SLOTS];
    logic [31:0] tag_next   [SLOTS];
    logic [SLOTS-1:0] alive_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   last_id_reg, last_id_next;
    logic          emitted_reg, emitted_next;
    teq_pkg::result_t res_reg, res_next;

    logic [SLOTS-1:0] le_vec;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] due_vec;
    logic [31:0]      new_id;
    logic             out_free;
    logic             full;
    logic             hit;
    logic             head_due;
    logic             do_insert;
    logic             do_kill;
    logic             do_shift;

    assign out_free = !res_reg.valid || out_ready;
    assign full     = (cnt_reg == CW'(SLOTS));
    assign new_id   = ((last_id_reg + 32'd1) == 32'd0) ? 32'd1 : last_id_reg + 32'd1;
    assign hit      = |hit_vec;
    assign head_due = (cnt_reg != '0) && (wake_reg[0] <= cmd_reg.now_tick);
    assign result   = res_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            le_vec[i]  = (CW'(i) < cnt_reg) && (wake_reg[i] <= cmd_reg.wake_time);
            hit_vec[i] = (idx_reg == CW'(i)) && alive_reg[i]
                         && (ident_reg[i] == cmd_reg.cancel_handle);
            due_vec[i] = (CW'(i) < cnt_reg) && (wake_reg[i] <= cmd_reg.now_tick)
                         && alive_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_head.opcode)
                        teq_pkg::OP_REGISTER: state_next = teq_pkg::ST_REG;
                        teq_pkg::OP_CANCEL:   state_next = teq_pkg::ST_SCAN;
                        default:              state_next = teq_pkg::ST_POP;
                    endcase
                end
            end
            teq_pkg::ST_REG:
            begin
                if (out_free)
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_SCAN:
            begin
                if (out_free && (hit || idx_reg >= cnt_reg
                                 || cmd_reg.cancel_handle == 32'd0))
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_POP:
            begin
                if (!head_due && (emitted_reg || out_free))
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    // datapath control and result
    always_comb
    begin
        cmd_pop      = 1'b0;
        do_insert    = 1'b0;
        do_kill      = 1'b0;
        do_shift     = 1'b0;
        idx_next     = idx_reg;
        emitted_next = emitted_reg;
        last_id_next = last_id_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        if (out_ready)
        begin
            res_next.valid = 1'b0;
        end
        unique case (state_reg)
            teq_pkg::ST_IDLE:
            begin
                cmd_pop      = cmd_valid;
                idx_next     = '0;
                emitted_next = 1'b0;
            end
            teq_pkg::ST_REG:
            begin
                if (out_free)
                begin
                    res_next = '{1'b1, teq_pkg::EV_FULL, 32'd0, 16'd0, 32'd0, 1'b1};
                    if (!full)
                    begin
                        do_insert       = 1'b1;
                        last_id_next    = new_id;
                        cnt_next        = cnt_reg + CW'(1);
                        res_next.event_kind = teq_pkg::EV_REGISTERED;
                        res_next.handle = new_id;
                    end
                end
            end
            teq_pkg::ST_SCAN:
            begin
                if (cmd_reg.cancel_handle == 32'd0 || idx_reg >= cnt_reg)
                begin
                    if (out_free)
                    begin
                        res_next = '{1'b1, teq_pkg::EV_NOT_FOUND, cmd_reg.cancel_handle,
                                     16'd0, 32'd0, 1'b1};
                    end
                end
                else if (hit)
                begin
                    if (out_free)
                    begin
                        do_kill  = 1'b1;
                        res_next = '{1'b1, teq_pkg::EV_CANCELLED, cmd_reg.cancel_handle,
                                     16'd0, 32'd0, 1'b1};
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            teq_pkg::ST_POP:
            begin
                if (head_due)
                begin
                    if (!alive_reg[0])
                    begin
                        do_shift = 1'b1;
                        cnt_next = cnt_reg - CW'(1);
                    end
                    else if (out_free)
                    begin
                        do_shift     = 1'b1;
                        cnt_next     = cnt_reg - CW'(1);
                        emitted_next = 1'b1;
                        res_next = '{1'b1, teq_pkg::EV_EXPIRED, ident_reg[0], owner_reg[0],
                                     tag_reg[0], !(|due_vec[SLOTS-1:1])};
                    end
                end
                else if (!emitted_reg && out_free)
                begin
                    res_next = '{1'b1, teq_pkg::EV_NOTHING, 32'd0, 16'd0, 32'd0, 1'b1};
                end
            end
            default: ;
        endcase
    end

    // cell chain: insert in wake order, shift left on pop, kill on cancel hit
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            wake_next[i]  = wake_reg[i];
            ident_next[i] = ident_reg[i];
            owner_next[i] = owner_reg[i];
            tag_next[i]   = tag_reg[i];
            alive_next[i] = alive_reg[i] && !(do_kill && hit_vec[i]);
            if (do_insert && !le_vec[i])
            begin
                if (i == 0 || le_vec[(i == 0) ? 0 : i-1])
                begin
                    wake_next[i]  = cmd_reg.wake_time;
                    ident_next[i] = new_id;
                    owner_next[i] = cmd_reg.owner_process;
                    tag_next[i]   = cmd_reg.user_tag;
                    alive_next[i] = 1'b1;
                end
                else
                begin
                    wake_next[i]  = wake_reg[(i == 0) ? 0 : i-1];
                    ident_next[i] = ident_reg[(i == 0) ? 0 : i-1];
                    owner_next[i] = owner_reg[(i == 0) ? 0 : i-1];
                    tag_next[i]   = tag_reg[(i == 0) ? 0 : i-1];
                    alive_next[i] = alive_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (do_shift && i < SLOTS-1)
            begin
                wake_next[i]  = wake_reg[(i < SLOTS-1) ? i+1 : i];
                ident_next[i] = ident_reg[(i < SLOTS-1) ? i+1 : i];
                owner_next[i] = owner_reg[(i < SLOTS-1) ? i+1 : i];
                tag_next[i]   = tag_reg[(i < SLOTS-1) ? i+1 : i];
                alive_next[i] = alive_reg[(i < SLOTS-1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= teq_pkg::ST_IDLE;
            cnt_reg     <= '0;
            last_id_reg <= 32'd0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_id_reg <= last_id_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg            <= idx_next;
        emitted_reg        <= emitted_next;
        alive_reg          <= alive_next;
        if (cmd_pop)
        begin
            cmd_reg <= cmd_head;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            wake_reg[i]  <= wake_next[i];
            ident_reg[i] <= ident_next[i];
            owner_reg[i] <= owner_next[i];
            tag_reg[i]   <= tag_next[i];
        end
    end

endmodule

// File: src/timer_expiry_queue_unit.sv
// Timer expiry queue: holds up to 64 pending timers sorted by wake tick.
// Input channel s_axis: tuser carries the opcode (register, cancel, tick),
// tdata the register fields, the cancel id and the current tick.
// Output channel m_axis: tuser carries the event kind, tdata the id, owner
// and tag of the timer concerned; tlast marks the last result of an item.
// A register item passes the command queue and the back-end command
// register before its result is written; a cancel scans the sorted
// cell chain one cell a cycle; a tick pops due timers from the chain head
// one per cycle, drops cancelled ones and, while the result register is
// free, emits one expired result per cycle for each live one, or a single
// nothing-due result if none was live. The back end runs one item at a time.
// A two-entry command queue decouples input accept from execution, so the
// front keeps accepting items while results wait on the receiver.
// When m_axis_tready is low a pending result holds and the back-end stalls
// at its next result; the queue then fills and s_axis_tready drops.
// Reset empties the store and restarts ids at 1; timer contents need no
// clearing since only occupied cells are read.
module timer_expiry_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // tdata: wake_time[31:0], owner_process[47:32], user_tag[79:48],
    //        cancel_handle[111:80], now_tick[143:112]
    input  logic [143:0]   s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // tdata: handle[31:0], fired_owner[47:32], fired_tag[79:48]
    output logic [79:0]    m_axis_tdata,
    // tuser: event_kind[2:0]
    output logic [2:0]     m_axis_tuser,
    output logic           m_axis_tlast
);

    teq_pkg::cmd_t    in_cmd;
    teq_pkg::cmd_t    cmd_head;
    teq_pkg::result_t result;
    logic             cmd_valid;
    logic             cmd_pop;

    // unpack the input item
    assign in_cmd.opcode        = s_axis_tuser;
    assign in_cmd.wake_time     = s_axis_tdata[31:0];
    assign in_cmd.owner_process = s_axis_tdata[47:32];
    assign in_cmd.user_tag      = s_axis_tdata[79:48];
    assign in_cmd.cancel_handle = s_axis_tdata[111:80];
    assign in_cmd.now_tick      = s_axis_tdata[143:112];

    teq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_head  (cmd_head)
    );

    teq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_head  (cmd_head),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // pack the result item
    assign m_axis_tvalid = result.valid;
    assign m_axis_tdata  = {result.fired_tag, result.fired_owner, result.handle};
    assign m_axis_tuser  = result.event_kind;
    assign m_axis_tlast  = result.final_flag;

endmodule

// File: src/teq_checker.sv
module teq_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [79:0]  m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= teq_pkg::EV_NOTHING)
        else $error("bad event kind");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != teq_pkg::EV_EXPIRED |-> m_axis_tlast)
        else $error("single result without last");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == teq_pkg::EV_FULL
                          || m_axis_tuser == teq_pkg::EV_NOTHING)
        |-> m_axis_tdata[31:0] == 32'd0)
        else $error("full or nothing due with nonzero handle");

endmodule

bind timer_expiry_queue_unit teq_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
